// ===== hdl/rhsg_pkg.sv =====
// rhsg_pkg: shared types and constants for the row highlight span generator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rhsg_pkg;

  // vertical gap trimmed from each row band, capped at cell height - 1
  localparam int ROW_GAP = 0;
  // default frame row count, counter wraps at this value
  localparam int MAX_ROWS_DEF = 4096;

  localparam int COL_W   = 13;
  localparam int DISP_W  = 12;
  localparam int WORD_W  = 32;
  localparam int SEGW_W  = 20;
  localparam int SCROLL_W = 48;
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 6;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SEG  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_GRID_LEFT   = 3'd0,
    REG_GRID_TOP    = 3'd1,
    REG_BAND_PX     = 3'd2,
    REG_COL_COUNT   = 3'd3,
    REG_CELL_WIDTH  = 3'd4,
    REG_CELL_HEIGHT = 3'd5,
    REG_INSET       = 3'd6,
    REG_SCROLL      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] grid_left;
    logic [15:0] grid_top;
    logic [15:0] band_px;
    logic [11:0] column_count;
    logic [7:0]  cell_width;
    logic [7:0]  cell_height;
    logic [7:0]  inset_px;
  } geom_t;

  typedef struct packed {
    logic [WORD_W-1:0] top_row;
    logic [7:0]        sub_off;
  } scroll_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] seg_x;
    logic [WORD_W-1:0] seg_y;
    logic [SEGW_W-1:0] seg_width;
    logic [7:0]        seg_height;
    logic [WORD_W-1:0] scroll_row;
  } seg_res_t;

endpackage

// ===== hdl/rhsg_scroll.sv =====
// rhsg_scroll: splits the q.16 scroll position into top row and pixel offset
// depends on rhsg_pkg
`timescale 1ns / 1ps

module rhsg_scroll (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rhsg_pkg::SCROLL_W-1:0] scroll_position,
  input  logic [7:0]                    cell_height,
  output rhsg_pkg::scroll_t             scroll
);

  logic [23:0]                 prod;
  logic [7:0]                  base;
  logic [7:0]                  base_rnd;
  logic [rhsg_pkg::WORD_W-1:0] whole;
  rhsg_pkg::scroll_t           scroll_r;
  rhsg_pkg::scroll_t           scroll_nxt;

  always_comb begin
    prod  = {8'd0, scroll_position[15:0]} * {16'd0, cell_height};
    base  = prod[23:16];
    whole = scroll_position[47:16];
    // round half to even on the fraction bits
    if (prod[15] && ((prod[14:0] != 15'd0) || base[0])) begin
      base_rnd = base + 8'd1;
    end else begin
      base_rnd = base;
    end
    // a full cell of offset moves the top row instead
    if (base_rnd >= cell_height) begin
      scroll_nxt.top_row = whole + 32'd1;
      scroll_nxt.sub_off = 8'd0;
    end else begin
      scroll_nxt.top_row = whole;
      scroll_nxt.sub_off = base_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r <= '0;
    end else begin
      scroll_r <= scroll_nxt;
    end
  end

  assign scroll = scroll_r;

endmodule

// ===== hdl/rhsg_span.sv =====
// rhsg_span: per-row highlight rectangle, range check and band clipping
// depends on rhsg_pkg
`timescale 1ns / 1ps

module rhsg_span #(
  parameter int CNT_W = 12
) (
  input  rhsg_pkg::geom_t              geom,
  input  rhsg_pkg::scroll_t            scroll,
  input  logic                         has_span,
  input  logic [rhsg_pkg::COL_W-1:0]   span_start,
  input  logic [rhsg_pkg::COL_W-1:0]   span_end,
  input  logic [CNT_W-1:0]             disp,
  output rhsg_pkg::seg_res_t           res
);

  localparam logic [7:0] GAP = 8'(rhsg_pkg::ROW_GAP);

  logic        grid_on;
  logic        bad;
  logic [12:0] diff;
  logic [19:0] raw;
  logic [19:0] max_inset;
  logic [7:0]  inset;
  logic [19:0] colpx;
  logic [7:0]  gap;
  logic [7:0]  band;
  logic [CNT_W+7:0] rowpx;
  logic [31:0] gl_ext;
  logic [31:0] gt_ext;
  logic [31:0] x;
  logic [31:0] y;
  logic        outside;

  always_comb begin
    grid_on = (geom.column_count != 12'd0) && (geom.cell_width != 8'd0) &&
              (geom.cell_height != 8'd0) && has_span;
    bad = span_start[12] || ($signed(span_end) <= $signed(span_start)) ||
          ($signed({span_end[12], span_end}) > $signed({2'b00, geom.column_count}));
    diff  = span_end - span_start;
    raw   = {8'd0, diff[11:0]} * {12'd0, geom.cell_width};
    max_inset = (raw - 20'd1) >> 1;
    inset = ({12'd0, geom.inset_px} < max_inset) ? geom.inset_px : max_inset[7:0];
    colpx = {8'd0, span_start[11:0]} * {12'd0, geom.cell_width};

    gap  = (GAP >= geom.cell_height) ? (geom.cell_height - 8'd1) : GAP;
    band = geom.cell_height - gap;
    rowpx = {8'd0, disp} * {{CNT_W{1'b0}}, geom.cell_height};

    gl_ext = {{16{geom.grid_left[15]}}, geom.grid_left};
    gt_ext = {{16{geom.grid_top[15]}}, geom.grid_top};
    x = {12'd0, colpx} + gl_ext + {24'd0, inset};
    y = 32'(rowpx) + gt_ext - {24'd0, scroll.sub_off} + {25'd0, gap[7:1]};

    outside = ($signed(y + {24'd0, band}) <= $signed(gt_ext)) ||
              ($signed(y) >= $signed(gt_ext + {16'd0, geom.band_px}));

    res = '0;
    if (grid_on) begin
      if (bad) begin
        res.kind = rhsg_pkg::KIND_ERR;
      end else if (!outside) begin
        res.kind         = rhsg_pkg::KIND_SEG;
        res.seg_x        = x;
        res.seg_y        = y;
        res.seg_width    = raw - {11'd0, inset, 1'b0};
        res.seg_height   = band;
        res.scroll_row   = scroll.top_row + 32'(disp);
      end
    end
  end

endmodule

// ===== hdl/row_highlight_span_generator.sv =====
// row_highlight_span_generator: top level with apb registers, row counter,
// input stage and result register; depends on rhsg_pkg, rhsg_scroll, rhsg_span
// result path: an accepted item enters the input register, then the result register loads it when empty or taken
// throughput: one item per cycle while out_tready is high; a stalled output holds the result and input registers
// reset (rst_n, synchronous, active low) clears config and scroll registers, row counter and valids
`timescale 1ns / 1ps

module row_highlight_span_generator #(
  parameter int MAX_ROWS = rhsg_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: span_start[12:0], span_end[25:13], zero pad [31:26]
  input  logic [31:0]                 in_tdata,
  // in_tuser: has_span
  input  logic                        in_tuser,
  input  logic                        in_tlast,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // out_tdata: seg_x[31:0], seg_y[63:32], seg_width[83:64], seg_height[91:84],
  // scroll_row[123:92], display_index[135:124], out_start[148:136],
  // out_end[161:149], zero pad [167:162]
  output logic [167:0]                out_tdata,
  // out_tuser: kind
  output logic [1:0]                  out_tuser,
  output logic                        out_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rhsg_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rhsg_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rhsg_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CNT_W = $clog2(MAX_ROWS);
  localparam int DW    = rhsg_pkg::DISP_W;

  // configuration
  rhsg_pkg::geom_t           geom_r;
  logic [rhsg_pkg::SCROLL_W-1:0] scroll_pos_r;
  rhsg_pkg::reg_idx_t        idx;
  logic                      cfg_wr;

  // row counter and stages
  logic [CNT_W-1:0]          row_cnt_r;
  logic [CNT_W-1:0]          row_cnt_nxt;
  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  logic                      s1_has_r;
  logic [rhsg_pkg::COL_W-1:0] s1_start_r;
  logic [rhsg_pkg::COL_W-1:0] s1_end_r;
  logic                      s1_last_r;
  logic [CNT_W-1:0]          s1_disp_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [167:0]              out_data_r;
  logic [167:0]              out_data_nxt;
  logic [1:0]                out_user_r;
  logic                      out_last_r;
  logic                      in_acc;
  logic                      s2_load;
  logic [DW+CNT_W-1:0]       disp_ext;

  rhsg_pkg::scroll_t         scroll;
  rhsg_pkg::seg_res_t        res;

  assign idx        = rhsg_pkg::reg_idx_t'(cfg_paddr[5:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r       <= '0;
      scroll_pos_r <= '0;
    end else if (cfg_wr) begin
      unique case (idx)
        rhsg_pkg::REG_GRID_LEFT:   geom_r.grid_left    <= cfg_pwdata[15:0];
        rhsg_pkg::REG_GRID_TOP:    geom_r.grid_top     <= cfg_pwdata[15:0];
        rhsg_pkg::REG_BAND_PX:     geom_r.band_px      <= cfg_pwdata[15:0];
        rhsg_pkg::REG_COL_COUNT:   geom_r.column_count <= cfg_pwdata[11:0];
        rhsg_pkg::REG_CELL_WIDTH:  geom_r.cell_width   <= cfg_pwdata[7:0];
        rhsg_pkg::REG_CELL_HEIGHT: geom_r.cell_height  <= cfg_pwdata[7:0];
        rhsg_pkg::REG_INSET:       geom_r.inset_px     <= cfg_pwdata[7:0];
        rhsg_pkg::REG_SCROLL:      scroll_pos_r        <= cfg_pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rhsg_pkg::REG_GRID_LEFT:   cfg_prdata = {48'd0, geom_r.grid_left};
      rhsg_pkg::REG_GRID_TOP:    cfg_prdata = {48'd0, geom_r.grid_top};
      rhsg_pkg::REG_BAND_PX:     cfg_prdata = {48'd0, geom_r.band_px};
      rhsg_pkg::REG_COL_COUNT:   cfg_prdata = {52'd0, geom_r.column_count};
      rhsg_pkg::REG_CELL_WIDTH:  cfg_prdata = {56'd0, geom_r.cell_width};
      rhsg_pkg::REG_CELL_HEIGHT: cfg_prdata = {56'd0, geom_r.cell_height};
      rhsg_pkg::REG_INSET:       cfg_prdata = {56'd0, geom_r.inset_px};
      rhsg_pkg::REG_SCROLL:      cfg_prdata = {16'd0, scroll_pos_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  rhsg_scroll u_scroll (
    .clk             (clk),
    .rst_n           (rst_n),
    .scroll_position (scroll_pos_r),
    .cell_height     (geom_r.cell_height),
    .scroll          (scroll)
  );

  // handshake: the result register frees up when empty or taken
  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (in_tlast) begin
      row_cnt_nxt = '0;
    end else if (row_cnt_r == CNT_W'(MAX_ROWS - 1)) begin
      row_cnt_nxt = '0;
    end else begin
      row_cnt_nxt = row_cnt_r + CNT_W'(1);
    end
    s1_valid_nxt  = in_acc ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = s2_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        row_cnt_r <= row_cnt_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_has_r   <= in_tuser;
      s1_start_r <= in_tdata[12:0];
      s1_end_r   <= in_tdata[25:13];
      s1_last_r  <= in_tlast;
      s1_disp_r  <= row_cnt_r;
    end
  end

  rhsg_span #(
    .CNT_W (CNT_W)
  ) u_span (
    .geom       (geom_r),
    .scroll     (scroll),
    .has_span   (s1_has_r),
    .span_start (s1_start_r),
    .span_end   (s1_end_r),
    .disp       (s1_disp_r),
    .res        (res)
  );

  assign disp_ext = {{DW{1'b0}}, s1_disp_r};

  always_comb begin
    out_data_nxt = {6'd0, s1_end_r, s1_start_r, disp_ext[DW-1:0], res.scroll_row,
                    res.seg_height, res.seg_width, res.seg_y, res.seg_x};
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= res.kind;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

endmodule
